// ===== hw/rtl/wcs_pkg.sv =====
// ---------------------------------------------------------------------------
// wcs_pkg: wall column span setup shared types and constants
// Projection constants, cordic angle table and the beat structs that travel
// down the cell chain.
// ---------------------------------------------------------------------------
package wcs_pkg;

  localparam int SCREEN_HEIGHT = 512;
  localparam int TILE_SIZE     = 64;
  localparam int TEXTURE_WIDTH = 64;

  localparam longint PROJ  = longint'(TILE_SIZE) * longint'(SCREEN_HEIGHT);
  localparam longint FULL  = longint'(SCREEN_HEIGHT) * 256;
  localparam longint NUM   = PROJ * 65536;
  localparam int     NUM_W = $clog2(NUM + 1);
  localparam longint U_DIV = longint'(TILE_SIZE) * 256;

  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_X0    = 39797;
  localparam int ATAN_W       = 17;

  localparam logic [ATAN_W-1:0] ATAN_STEPS [CORDIC_STEPS] = '{
    17'd8192, 17'd4836, 17'd2555, 17'd1297, 17'd651, 17'd326, 17'd163,
    17'd81, 17'd41, 17'd20, 17'd10, 17'd5, 17'd3, 17'd1
  };

  localparam logic [23:0] STEP_MAX  = 24'hFFFFFF;
  localparam logic [21:0] START_MAX = 22'h3FFFFF;

  typedef logic signed [19:0] cval_t;
  typedef logic signed [16:0] zval_t;

  // per-ray fields that ride alongside the arithmetic
  typedef struct packed {
    logic       valid;
    logic [9:0] column;
    logic [1:0] face;
    logic [5:0] u;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [23:0] len;
    logic        zero;
    cval_t       x;
    cval_t       y;
    zval_t       z;
  } cord_t;

  typedef struct packed {
    side_t            side;
    logic [23:0]      ray_dist;
    logic [23:0]      step;
    logic [23:0]      rem;
    logic [NUM_W-1:0] quo;
  } div_t;

endpackage

// ===== hw/rtl/wcs_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// wcs_cordic_cell: one rotation step of the cosine cordic
// Rotates x/y by the fixed angle of its step and registers the beat.
// ---------------------------------------------------------------------------
module wcs_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  wcs_pkg::cord_t d_in,
  output wcs_pkg::cord_t d_out
);
  import wcs_pkg::*;

  cord_t d_r, d_nxt;
  cval_t xs, ys;

  always_comb begin
    xs    = d_in.x >>> STEP;
    ys    = d_in.y >>> STEP;
    d_nxt = d_in;
    if (!d_in.z[ATAN_W-1]) begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.z = d_in.z - zval_t'(ATAN_STEPS[STEP]);
    end else begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.z = d_in.z + zval_t'(ATAN_STEPS[STEP]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.side.valid <= 1'b0;
    end else begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// ===== hw/rtl/wcs_div_cell.sv =====
// ---------------------------------------------------------------------------
// wcs_div_cell: one restoring step of the height divider
// Brings down one bit of the constant numerator and produces one quotient bit.
// ---------------------------------------------------------------------------
module wcs_div_cell #(
  parameter int BIT = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  wcs_pkg::div_t d_in,
  output wcs_pkg::div_t d_out
);
  import wcs_pkg::*;

  localparam logic [NUM_W-1:0] NUM_V = NUM_W'(NUM);

  div_t        d_r, d_nxt;
  logic [24:0] r_sh;
  logic [24:0] r_sub;
  logic        fits;

  always_comb begin
    r_sh  = {d_in.rem, NUM_V[BIT]};
    r_sub = r_sh - {1'b0, d_in.ray_dist};
    fits  = (r_sh >= {1'b0, d_in.ray_dist});
    d_nxt = d_in;
    d_nxt.rem = fits ? r_sub[23:0] : r_sh[23:0];
    d_nxt.quo = {d_in.quo[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.side.valid <= 1'b0;
    end else begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// ===== hw/rtl/wall_column_span_setup_top.sv =====
// ---------------------------------------------------------------------------
// wall_column_span_setup_top: per-ray wall slice setup
// Fisheye correction, wall projection, texture step/start and texel column.
// ---------------------------------------------------------------------------
// One ray is taken every clock cycle; busy never rises. Each ray gives one
// result on the out_ ports, marked by out_valid for a single cycle, after it
// has passed through an input register, a 14-cell cordic chain for the cosine,
// one multiply stage, one step stage, a divider chain of one cell per numerator
// bit for the height, and three clamp/output stages. Results come out in input
// order and cannot be held.
module wall_column_span_setup_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_column,
  input  logic [23:0] in_ray_length,
  input  logic [15:0] in_ray_angle,
  input  logic [15:0] in_view_angle,
  input  logic [1:0]  in_wall_face,
  input  logic [23:0] in_hit_x,
  input  logic [23:0] in_hit_y,
  output logic        out_valid,
  output logic [9:0]  out_column_out,
  output logic [8:0]  out_line_top,
  output logic [9:0]  out_line_rows,
  output logic [5:0]  out_texel_column,
  output logic [21:0] out_texel_row_start,
  output logic [23:0] out_texel_row_step,
  output logic [1:0]  out_texture_select
);
  import wcs_pkg::*;

  // input stage
  cord_t       chain [CORDIC_STEPS+1];
  cord_t       s0_nxt;
  logic [15:0] diff;
  logic [15:0] ang;
  logic [23:0] hit;
  logic [47:0] u_full;
  logic [5:0]  u_raw;
  logic        mirror;

  assign busy = 1'b0;

  always_comb begin
    diff = in_view_angle - in_ray_angle;
    ang  = (diff > 16'd32768) ? (16'd0 - diff) : diff;
    if (in_wall_face < 2'd2) begin
      hit    = in_hit_x;
      mirror = in_ray_angle > 16'd32768;
    end else begin
      hit    = in_hit_y;
      mirror = (in_ray_angle < 16'd16384) || (in_ray_angle > 16'd49152);
    end
    u_full = ((48'(hit) * 48'(TEXTURE_WIDTH)) / 48'(U_DIV)) % 48'(TEXTURE_WIDTH);
    u_raw  = 6'(u_full);
    s0_nxt.side.valid  = start;
    s0_nxt.side.column = in_column;
    s0_nxt.side.face   = in_wall_face;
    s0_nxt.side.u      = mirror ? 6'(TEXTURE_WIDTH - 1) - u_raw : u_raw;
    s0_nxt.len  = in_ray_length;
    s0_nxt.zero = ang >= 16'd16384;
    s0_nxt.x    = cval_t'(CORDIC_X0);
    s0_nxt.y    = '0;
    s0_nxt.z    = zval_t'({1'b0, ang});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0].side.valid <= 1'b0;
    end else begin
      chain[0] <= s0_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    wcs_cordic_cell #(.STEP(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  // cosine clamp and distance multiply
  cord_t       cend;
  logic [16:0] cosv;
  logic [40:0] dprod;
  side_t       m_side_r;
  logic [23:0] m_dist_r;

  assign cend = chain[CORDIC_STEPS];

  always_comb begin
    if (cend.zero || cend.x[19]) begin
      cosv = '0;
    end else if (cend.x > cval_t'(65536)) begin
      cosv = 17'd65536;
    end else begin
      cosv = 17'(cend.x);
    end
    dprod = 41'(cend.len) * 41'(cosv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_side_r.valid <= 1'b0;
    end else begin
      m_side_r <= cend.side;
      m_dist_r <= dprod[39:16];
    end
  end

  // texture step, divider entry
  div_t        dchain [NUM_W+1];
  div_t        d0_nxt;
  logic [47:0] step_full;

  always_comb begin
    step_full = (48'(m_dist_r) * 48'(TEXTURE_WIDTH) * 48'd256) / 48'(PROJ);
    d0_nxt.side     = m_side_r;
    d0_nxt.ray_dist = m_dist_r;
    d0_nxt.step     = (step_full > 48'(STEP_MAX)) ? STEP_MAX : step_full[23:0];
    d0_nxt.rem      = '0;
    d0_nxt.quo      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dchain[0].side.valid <= 1'b0;
    end else begin
      dchain[0] <= d0_nxt;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    wcs_div_cell #(.BIT(NUM_W - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (dchain[k]),
      .d_out (dchain[k+1])
    );
  end

  // clamp to screen height
  localparam logic [NUM_W-1:0] FULL_V = NUM_W'(FULL);

  div_t             dend;
  side_t            a_side_r, b_side_r;
  logic [NUM_W-1:0] a_hq_r, a_hq_nxt, b_hq_r;
  logic [NUM_W-1:0] a_off_r, a_off_nxt;
  logic [23:0]      a_step_r, a_step_nxt, b_step_r;
  logic [NUM_W+23:0] b_prod_r;

  assign dend = dchain[NUM_W];

  always_comb begin
    a_off_nxt  = '0;
    a_step_nxt = dend.step;
    a_hq_nxt   = dend.quo;
    if (dend.ray_dist == '0) begin
      a_hq_nxt   = FULL_V;
      a_step_nxt = '0;
    end else if (dend.quo > FULL_V) begin
      a_off_nxt = (dend.quo - FULL_V) >> 1;
      a_hq_nxt  = FULL_V;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_side_r.valid <= 1'b0;
      b_side_r.valid <= 1'b0;
    end else begin
      a_side_r <= dend.side;
      a_hq_r   <= a_hq_nxt;
      a_off_r  <= a_off_nxt;
      a_step_r <= a_step_nxt;
      b_side_r <= a_side_r;
      b_hq_r   <= a_hq_r;
      b_step_r <= a_step_r;
      b_prod_r <= (NUM_W+24)'(a_off_r) * (NUM_W+24)'(a_step_r);
    end
  end

  // output register
  logic [NUM_W+23:0] start_sh;
  logic [NUM_W-1:0]  top_full;
  logic              valid_r;
  logic [9:0]        column_r, rows_r;
  logic [8:0]        top_r;
  logic [5:0]        u_r;
  logic [21:0]       start_r;
  logic [23:0]       step_r;
  logic [1:0]        face_r;

  always_comb begin
    start_sh = b_prod_r >> 8;
    top_full = (FULL_V - b_hq_r) >> 9;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r  <= b_side_r.valid;
      column_r <= b_side_r.column;
      face_r   <= b_side_r.face;
      u_r      <= b_side_r.u;
      step_r   <= b_step_r;
      rows_r   <= 10'(b_hq_r >> 8);
      top_r    <= 9'(top_full);
      start_r  <= (start_sh > (NUM_W+24)'(START_MAX)) ? START_MAX : start_sh[21:0];
    end
  end

  assign out_valid           = valid_r;
  assign out_column_out      = column_r;
  assign out_line_top        = top_r;
  assign out_line_rows       = rows_r;
  assign out_texel_column    = u_r;
  assign out_texel_row_start = start_r;
  assign out_texel_row_step  = step_r;
  assign out_texture_select  = face_r;

  // a slice never exceeds the screen
  a_rows_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_rows <= 10'(SCREEN_HEIGHT))
    else $error("slice taller than screen");

  // a texture start offset only arises on a clamped slice
  a_start_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_texel_row_start != '0) |-> out_line_top == '0)
    else $error("start offset on an unclamped slice");

  // zero step means zero or tiny distance, so full height
  a_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_texel_row_step == '0) |-> out_line_rows == 10'(SCREEN_HEIGHT))
    else $error("zero step without full height");

endmodule
